>>> rtl/min_falling_path_sum_unit_macros.svh
// Assertion macros used by the minimum falling path sum RTL.
`ifndef MIN_FALLING_PATH_SUM_UNIT_MACROS_SVH
`define MIN_FALLING_PATH_SUM_UNIT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MFPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define MFPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mfps_pkg.sv
// Package with sizes and constants of the minimum falling path sum unit.
package mfps_pkg;

  localparam int MaxCols   = 1024;
  localparam int CellWidth = 16;
  localparam int SumWidth  = 32;
  localparam int RowCntW   = 16;
  localparam int ColCntW   = 11;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 4;
  localparam int AddrW     = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int ColW      = AddrW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_COUNT = 4'd0,
    CFG_COL_COUNT = 4'd1
  } cfg_idx_e;

  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

  function automatic logic signed [SumWidth-1:0] smin(
    input logic signed [SumWidth-1:0] a,
    input logic signed [SumWidth-1:0] b
  );
    smin = (a < b) ? a : b;
  endfunction

endpackage

>>> rtl/min_falling_path_sum_unit.sv
// The result word appears in the cycle after the last cell of a grid is accepted.
// One cell per cycle while in_stall_o is low; the row-store RAM does one read and one
// write per cell; the read for column c+2 goes out with cell c, hiding the registered read.
// Reset: asynchronous, active low; counters clear, row and column counts become one.
// Row-store contents are not cleared; a grid's first row writes every entry later rows use.
module min_falling_path_sum_unit
  import mfps_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [CellWidth-1:0] cell_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SumWidth-1:0]  min_sum_o
);

`include "min_falling_path_sum_unit_macros.svh"

  // Configuration registers.
  logic [RowCntW-1:0] row_count_q;
  logic [ColCntW-1:0] col_count_q;

  // Position within the grid.
  logic [AddrW-1:0]   col_q, col_d;
  logic [RowCntW-1:0] row_q, row_d;

  // Sliding window over the previous row: left = old[c-1], mid = old[c].
  // old[c+1] comes from the RAM read data or the bypass register.
  logic signed [SumWidth-1:0] left_q, left_d;
  logic signed [SumWidth-1:0] mid_q, mid_d;
  logic signed [SumWidth-1:0] col0_q;
  logic                       byp_q, byp_d;
  logic signed [SumWidth-1:0] byp_data_q;
  logic signed [SumWidth-1:0] rmin_q, rmin_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SumWidth-1:0] min_sum_q;

  logic [ColW-1:0]    cols_eff;
  logic [RowCntW:0]   rows_eff;
  logic [ColW-1:0]    col_next;
  logic               row_end;
  logic               last_row;
  logic               final_cell;
  logic               in_accept;

  logic signed [SumWidth-1:0] ram_rdata;
  logic signed [SumWidth-1:0] right_old;
  logic signed [SumWidth-1:0] best;
  logic signed [SumWidth:0]   sum_wide;
  logic signed [SumWidth-1:0] sum;
  logic signed [SumWidth-1:0] grid_min;
  logic [AddrW-1:0]           rd_addr;

  // Clamp the column count to one..MaxCols and the row count to at least one.
  always_comb begin
    if (col_count_q == '0) begin
      cols_eff = ColW'(1);
    end else if (32'(col_count_q) > 32'(MaxCols)) begin
      cols_eff = ColW'(MaxCols);
    end else begin
      cols_eff = ColW'(col_count_q);
    end
    rows_eff = (row_count_q == '0) ? (RowCntW + 1)'(1) : {1'b0, row_count_q};
  end

  assign col_next   = {1'b0, col_q} + ColW'(1);
  assign row_end    = (col_next == cols_eff);
  assign last_row   = ({1'b0, row_q} + (RowCntW + 1)'(1) == rows_eff);
  assign final_cell = row_end && last_row;

  // Hold the last cell of a grid while an earlier result still waits.
  assign in_stall_o = out_valid_q && out_stall_i && final_cell;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Cell sum: value plus the least existing neighbor of the previous row (zero on the first row), saturated.
  always_comb begin
    right_old = byp_q ? byp_data_q : ram_rdata;
    best      = mid_q;
    if (col_q != '0) begin
      best = smin(best, left_q);
    end
    if (!row_end) begin
      best = smin(best, right_old);
    end
    if (row_q == '0) begin
      best = '0;
    end
    sum_wide = (SumWidth + 1)'(cell_value_i) + (SumWidth + 1)'(best);
    if (sum_wide > (SumWidth + 1)'(SumMax)) begin
      sum = SumMax;
    end else if (sum_wide < (SumWidth + 1)'(SumMin)) begin
      sum = SumMin;
    end else begin
      sum = sum_wide[SumWidth-1:0];
    end
    grid_min = smin(rmin_q, sum);
  end

  // Window advance and read-ahead address.
  always_comb begin
    left_d = mid_q;
    if (row_end) begin
      // Next cell is column 0 of the next row: it needs the sums just written.
      mid_d   = (col_q == '0) ? sum : col0_q;
      rd_addr = AddrW'(1);
    end else begin
      mid_d   = right_old;
      rd_addr = AddrW'({1'b0, col_q} + ColW'(2));
    end
    // Forward the word written this cycle if the read hits the same entry.
    byp_d = (rd_addr == col_q);
  end

  // Counters, running minimum and output word.
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    rmin_d      = rmin_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cfg_we_i && (cfg_index_i == CFG_ROW_COUNT || cfg_index_i == CFG_COL_COUNT)) begin
      col_d  = '0;
      row_d  = '0;
      rmin_d = SumMax;
    end else if (in_accept) begin
      if (last_row) begin
        rmin_d = grid_min;
      end
      if (row_end) begin
        col_d = '0;
        if (last_row) begin
          row_d       = '0;
          rmin_d      = SumMax;
          out_valid_d = 1'b1;
        end else begin
          row_d = row_q + RowCntW'(1);
        end
      end else begin
        col_d = col_next[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCntW'(1);
      col_count_q <= ColCntW'(1);
      col_q       <= '0;
      row_q       <= '0;
      rmin_q      <= SumMax;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_ROW_COUNT) begin
        row_count_q <= cfg_data_i[RowCntW-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_COL_COUNT) begin
        col_count_q <= cfg_data_i[ColCntW-1:0];
      end
      col_q       <= col_d;
      row_q       <= row_d;
      rmin_q      <= rmin_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        byp_q <= byp_d;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      left_q     <= left_d;
      mid_q      <= mid_d;
      byp_data_q <= sum;
      if (col_q == '0) begin
        col0_q <= sum;
      end
      if (final_cell) begin
        min_sum_q <= grid_min;
      end
    end
  end

  // Row store: write the new sum of column c, read ahead the next window entry.
  mfps_ram #(
    .Width (SumWidth),
    .Depth (MaxCols)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (col_q),
    .wdata_i (sum),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign min_sum_o   = min_sum_q;

  `MFPS_ASSERT_SAME(a_col_range, 1'b1, {1'b0, col_q} < cols_eff, "column index out of range")
  `MFPS_ASSERT_SAME(a_out_source, $rose(out_valid_q), $past(in_accept && final_cell), "result without final cell")
  `MFPS_ASSERT_NEXT(a_row_step, in_accept && row_end && !last_row && !cfg_we_i, col_q == '0 && row_q == $past(row_q) + RowCntW'(1), "row advance broken")
  `MFPS_ASSERT_NEXT(a_cfg_restart, cfg_we_i && cfg_index_i == CFG_COL_COUNT, col_q == '0 && row_q == '0, "config did not restart grid")

endmodule

>>> rtl/mfps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mfps_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  parameter int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
